[hdl/csc_pkg.sv]
// ============================================================================
// csc_pkg: shared types and constants for the climate sensor compensation
// Register indexes, field widths and the divider request layout.
// ============================================================================
package csc_pkg;

    localparam int CSC_IN_W    = 56;
    localparam int CSC_OUT_W   = 72;
    localparam int CSC_CFG_W   = 48;
    localparam int CSC_IDX_W   = 3;
    localparam int CSC_Q_W     = 64;
    localparam int CSC_D_W     = 31;
    localparam int CSC_DIV_STEPS = CSC_Q_W;

    localparam logic [CSC_IDX_W-1:0] CSC_REG_TEMP    = 3'd0;
    localparam logic [CSC_IDX_W-1:0] CSC_REG_PRESS_A = 3'd1;
    localparam logic [CSC_IDX_W-1:0] CSC_REG_PRESS_B = 3'd2;
    localparam logic [CSC_IDX_W-1:0] CSC_REG_PRESS_C = 3'd3;
    localparam logic [CSC_IDX_W-1:0] CSC_REG_HUMID_A = 3'd4;
    localparam logic [CSC_IDX_W-1:0] CSC_REG_HUMID_B = 3'd5;

    localparam logic signed [63:0] CSC_HUM_MAX_Q22 = 64'sd419430400;
    localparam logic [16:0]        CSC_HUM_OUT_MAX = 17'd102400;

    typedef struct packed {
        logic [15:0] temp;
        logic [16:0] hum;
        logic        pok;
    } t_side;

    typedef struct packed {
        logic [CSC_Q_W-1:0] nmag;
        logic [CSC_D_W-1:0] dmag;
        logic               neg;
        t_side              side;
    } t_div_req;

endpackage

[hdl/csc_div.sv]
// ============================================================================
// csc_div: pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero.
// ============================================================================
module csc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  csc_pkg::t_div_req i_req,
    output logic              o_vld,
    output logic [csc_pkg::CSC_Q_W-1:0] o_q,
    output csc_pkg::t_side    o_side
);
    import csc_pkg::*;

    typedef struct packed {
        logic [CSC_D_W-1:0] rem;
        logic [CSC_Q_W-1:0] nq;
        logic [CSC_D_W-1:0] dmag;
        logic               neg;
        t_side              side;
    } t_stage;

    t_stage             cur   [1:CSC_DIV_STEPS];
    t_stage             r_st  [1:CSC_DIV_STEPS];
    logic               r_vld [1:CSC_DIV_STEPS];
    logic               r_ovld;
    logic [CSC_Q_W-1:0] r_q;
    t_side              r_side;

    function automatic t_stage step(input t_stage s);
        logic [CSC_D_W:0] t;
        logic [CSC_D_W:0] d;
        t_stage           r;
        t = {s.rem, s.nq[CSC_Q_W-1]};
        d = {1'b0, s.dmag};
        r = s;
        if (t >= d) begin
            r.rem = CSC_D_W'(t - d);
            r.nq  = {s.nq[CSC_Q_W-2:0], 1'b1};
        end else begin
            r.rem = t[CSC_D_W-1:0];
            r.nq  = {s.nq[CSC_Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        cur[1].rem  = '0;
        cur[1].nq   = i_req.nmag;
        cur[1].dmag = i_req.dmag;
        cur[1].neg  = i_req.neg;
        cur[1].side = i_req.side;
        for (int k = 2; k <= CSC_DIV_STEPS; k++) begin
            cur[k] = r_st[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= CSC_DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_vld;
            for (int k = 2; k <= CSC_DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[CSC_DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= CSC_DIV_STEPS; k++) begin
                r_st[k] <= step(cur[k]);
            end
            r_q    <= r_st[CSC_DIV_STEPS].neg ? (CSC_Q_W'(0) - r_st[CSC_DIV_STEPS].nq)
                                              : r_st[CSC_DIV_STEPS].nq;
            r_side <= r_st[CSC_DIV_STEPS].side;
        end
    end

    assign o_vld  = r_ovld;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

[hdl/climate_sensor_compensation_core.sv]
// ============================================================================
// climate_sensor_compensation_core: integer compensation of a combined
// temperature, pressure and humidity reading
// ----------------------------------------------------------------------------
// Input stream: one raw reading per request on s_tdata
//   (adc_temp, adc_press, adc_humid). Output stream: one compensated result
//   per request on m_tdata (temp_centi, press_q24_8, humid_q10) with
//   press_valid on m_tuser.
// Calibration words are loaded through the write port; an unknown index is ignored.
//   Load them only while no reading is in flight; the block does not enforce it.
// An accepted request reaches m_tvalid through 12 front
//   stages for temperature, pressure coefficients and humidity, 65 stages
//   of the bit-per-stage pressure divider, 4 back stages and the output
//   register. Throughput is one reading per cycle while the receiver does not stall.
// The whole pipeline advances when the output register is empty or taken;
//   while the receiver stalls with a result waiting, s_tready is low and
//   every stage holds.
// Reset clears all valid bits and the calibration words.
// ============================================================================
module climate_sensor_compensation_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [csc_pkg::CSC_IN_W-1:0]  s_tdata,   // adc_temp, adc_press, adc_humid
    output logic m_tvalid,
    input  logic m_tready,
    output logic [csc_pkg::CSC_OUT_W-1:0] m_tdata,   // temp_centi, press_q24_8, humid_q10
    output logic [0:0] m_tuser,                      // press_valid
    input  logic i_cfg_we,
    input  logic [csc_pkg::CSC_IDX_W-1:0] i_cfg_idx,
    input  logic [csc_pkg::CSC_CFG_W-1:0] i_cfg_data
);
    import csc_pkg::*;

    logic        adv;
    logic [47:0] r_tcal, r_pca, r_pcb, r_pcc;
    logic [31:0] r_hca, r_hcb;

    logic signed [16:0] c_p1;
    logic signed [15:0] c_t2, c_t3, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9, c_h2;
    logic signed [8:0]  c_h1, c_h3;
    logic signed [11:0] c_h4, c_h5;
    logic signed [7:0]  c_h6;

    assign c_t2 = $signed(r_tcal[31:16]);
    assign c_t3 = $signed(r_tcal[47:32]);
    assign c_p1 = $signed({1'b0, r_pca[15:0]});
    assign c_p2 = $signed(r_pca[31:16]);
    assign c_p3 = $signed(r_pca[47:32]);
    assign c_p4 = $signed(r_pcb[15:0]);
    assign c_p5 = $signed(r_pcb[31:16]);
    assign c_p6 = $signed(r_pcb[47:32]);
    assign c_p7 = $signed(r_pcc[15:0]);
    assign c_p8 = $signed(r_pcc[31:16]);
    assign c_p9 = $signed(r_pcc[47:32]);
    assign c_h1 = $signed({1'b0, r_hca[7:0]});
    assign c_h2 = $signed(r_hca[23:8]);
    assign c_h3 = $signed({1'b0, r_hca[31:24]});
    assign c_h4 = $signed(r_hcb[11:0]);
    assign c_h5 = $signed(r_hcb[23:12]);
    assign c_h6 = $signed(r_hcb[31:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_pca  <= '0;
            r_pcb  <= '0;
            r_pcc  <= '0;
            r_hca  <= '0;
            r_hcb  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CSC_REG_TEMP:    r_tcal <= i_cfg_data;
                CSC_REG_PRESS_A: r_pca  <= i_cfg_data;
                CSC_REG_PRESS_B: r_pcb  <= i_cfg_data;
                CSC_REG_PRESS_C: r_pcc  <= i_cfg_data;
                CSC_REG_HUMID_A: r_hca  <= i_cfg_data[31:0];
                CSC_REG_HUMID_B: r_hcb  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // front pipeline
    logic        r_fv [1:12];
    logic [19:0] r_adcp [1:6];
    logic [15:0] r_adch [1:4];
    logic [15:0] r_temp [4:11];

    logic [19:0]        adc_t;
    logic signed [18:0] s1_a;
    logic signed [17:0] s1_b;
    logic signed [34:0] r1_at2;
    logic signed [35:0] r1_bb;
    logic signed [23:0] r2_v1;
    logic signed [37:0] r2_bt3;
    logic signed [24:0] r3_tf;

    logic signed [27:0] s4_t5;
    logic signed [19:0] s4_ts;
    logic [15:0]        s4_temp;
    logic signed [25:0] s4_pv1, s4_hv1;
    logic signed [25:0] r4_pv1;
    logic signed [51:0] r4_pv1sq;
    logic signed [37:0] r4_h5v;
    logic signed [33:0] r4_hv6;
    logic signed [34:0] r4_hv3;

    logic signed [67:0] s5_sq6, s5_sq3;
    logic signed [39:0] s5_ha;
    logic signed [63:0] r5_sq6, r5_sq3;
    logic signed [41:0] r5_v5, r5_v2;
    logic signed [24:0] r5_ha;
    logic signed [48:0] r5_hb;

    logic signed [63:0] r6_pv2, r6_pv1;
    logic signed [55:0] r6_hb;
    logic signed [24:0] r6_ha;

    logic signed [63:0] s7_u;
    logic signed [80:0] s7_q;
    logic [20:0]        s7_p;
    logic signed [56:0] s7_hbr;
    logic [63:0]        r7_q, r7_np;
    logic signed [42:0] r7_hbs;
    logic signed [24:0] r7_ha;

    logic signed [67:0] s8_x;
    logic signed [30:0] r8_d;
    logic [63:0]        r8_num;
    logic signed [63:0] r8_x;

    t_div_req    s9_req;
    logic [31:0] s9_xl, s9_xh32;
    t_div_req    r_dv [9:11];
    logic [63:0] r9_ll;
    logic [31:0] r9_lh;
    logic signed [63:0] r9_x;

    logic [63:0]        s10_sq;
    logic signed [56:0] r10_s7;
    logic signed [63:0] r10_x;

    logic signed [65:0] s11_m;
    logic signed [63:0] r11_m, r11_x;

    logic signed [63:0] s12_hx;
    logic [16:0]        s12_hum;
    t_div_req           s12_req;
    t_div_req           r12_req;

    assign adc_t = s_tdata[19:0];

    always_comb begin
        s1_a = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, r_tcal[15:0], 1'b0});
        s1_b = $signed({2'b00, adc_t[19:4]}) - $signed({2'b00, r_tcal[15:0]});

        s4_t5  = 28'(r3_tf) * 28'sd5 + 28'sd128;
        s4_ts  = $signed(s4_t5[27:8]);
        if (s4_ts > 20'sd32767) begin
            s4_temp = 16'h7FFF;
        end else if (s4_ts < -20'sd32768) begin
            s4_temp = 16'h8000;
        end else begin
            s4_temp = s4_ts[15:0];
        end
        s4_pv1 = 26'(r3_tf) - 26'sd128000;
        s4_hv1 = 26'(r3_tf) - 26'sd76800;

        s5_sq6 = r4_pv1sq * c_p6;
        s5_sq3 = r4_pv1sq * c_p3;
        s5_ha  = $signed({10'd0, r_adch[4], 14'd0}) - (40'(c_h4) <<< 20)
               - 40'(r4_h5v) + 40'sd16384;

        s7_u   = r6_pv1 + 64'sh0000_8000_0000_0000;
        s7_q   = s7_u * c_p1;
        s7_p   = 21'd1048576 - {1'b0, r_adcp[6]};
        s7_hbr = 57'(r6_hb) + 57'sd8192;

        s8_x = r7_ha * r7_hbs;

        s9_req.nmag      = r8_num[63] ? (64'd0 - r8_num) : r8_num;
        s9_req.dmag      = r8_d[30] ? 31'(-r8_d) : 31'(r8_d);
        s9_req.neg       = r8_num[63] ^ r8_d[30];
        s9_req.side.temp = '0;
        s9_req.side.hum  = '0;
        s9_req.side.pok  = (r8_d != 31'sd0);
        s9_xl   = r8_x[46:15];
        s9_xh32 = {{15{r8_x[63]}}, r8_x[63:47]};

        s10_sq = r9_ll + {r9_lh[30:0], 33'd0};

        s11_m = r10_s7 * c_h1;

        s12_hx = r11_x - (r11_m >>> 4);
        if (s12_hx[63]) begin
            s12_hum = '0;
        end else if (s12_hx > CSC_HUM_MAX_Q22) begin
            s12_hum = CSC_HUM_OUT_MAX;
        end else begin
            s12_hum = s12_hx[28:12];
        end
        s12_req           = r_dv[11];
        s12_req.side.temp = r_temp[11];
        s12_req.side.hum  = s12_hum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 12; k++) begin
                r_fv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_fv[1] <= s_tvalid;
            for (int k = 2; k <= 12; k++) begin
                r_fv[k] <= r_fv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_adcp[1] <= s_tdata[39:20];
            for (int k = 2; k <= 6; k++) begin
                r_adcp[k] <= r_adcp[k-1];
            end
            r_adch[1] <= s_tdata[55:40];
            for (int k = 2; k <= 4; k++) begin
                r_adch[k] <= r_adch[k-1];
            end
            r_temp[4] <= s4_temp;
            for (int k = 5; k <= 11; k++) begin
                r_temp[k] <= r_temp[k-1];
            end

            r1_at2 <= s1_a * c_t2;
            r1_bb  <= s1_b * s1_b;

            r2_v1  <= $signed(r1_at2[34:11]);
            r2_bt3 <= $signed(r1_bb[35:12]) * c_t3;

            r3_tf <= 25'(r2_v1) + 25'($signed(r2_bt3[37:14]));

            r4_pv1   <= s4_pv1;
            r4_pv1sq <= s4_pv1 * s4_pv1;
            r4_h5v   <= c_h5 * s4_hv1;
            r4_hv6   <= s4_hv1 * c_h6;
            r4_hv3   <= s4_hv1 * c_h3;

            r5_sq6 <= s5_sq6[63:0];
            r5_sq3 <= s5_sq3[63:0];
            r5_v5  <= r4_pv1 * c_p5;
            r5_v2  <= r4_pv1 * c_p2;
            r5_ha  <= $signed(s5_ha[39:15]);
            r5_hb  <= $signed(r4_hv6[33:10]) * (25'($signed(r4_hv3[34:11])) + 25'sd32768);

            r6_pv2 <= r5_sq6 + (64'(r5_v5) <<< 17) + (64'(c_p4) <<< 35);
            r6_pv1 <= (r5_sq3 >>> 8) + (64'(r5_v2) <<< 12);
            r6_hb  <= (40'($signed(r5_hb[48:10])) + 40'sd2097152) * c_h2;
            r6_ha  <= r5_ha;

            r7_q   <= s7_q[63:0];
            r7_np  <= ({43'd0, s7_p} << 31) - r6_pv2;
            r7_hbs <= $signed(s7_hbr[56:14]);
            r7_ha  <= r6_ha;

            r8_d   <= $signed(r7_q[63:33]);
            r8_num <= r7_np * 64'd3125;
            r8_x   <= s8_x[63:0];

            r_dv[9]  <= s9_req;
            r_dv[10] <= r_dv[9];
            r_dv[11] <= r_dv[10];
            r9_ll    <= s9_xl * s9_xl;
            r9_lh    <= s9_xl * s9_xh32;
            r9_x     <= r8_x;

            r10_s7 <= $signed(s10_sq[63:7]);
            r10_x  <= r9_x;

            r11_m <= s11_m[63:0];
            r11_x <= r10_x;

            r12_req <= s12_req;
        end
    end

    // pressure divider
    logic        div_vld;
    logic [63:0] div_q;
    t_side       div_side;

    csc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_fv[12]),
        .i_req   (r12_req),
        .o_vld   (div_vld),
        .o_q     (div_q),
        .o_side  (div_side)
    );

    // back pipeline
    logic               r_pv [1:4];
    logic [31:0]        p1_xl, p1_xh32;
    logic signed [79:0] p1_p8, p3_m;
    logic [63:0]        r_p1_ll, r_p2_xx;
    logic [31:0]        r_p1_lh;
    logic signed [63:0] r_p1_p8, r_p1_q, r_p2_v2, r_p2_q;
    logic signed [63:0] r_p3_m, r_p3_v2, r_p3_q, r_p4_s;
    t_side              r_p1_side, r_p2_side, r_p3_side, r_p4_side;
    logic [31:0]        o_press;

    logic        r_ovld;
    logic [15:0] r_otemp;
    logic [31:0] r_opress;
    logic        r_opv;
    logic [16:0] r_ohum;

    always_comb begin
        p1_xl   = div_q[44:13];
        p1_xh32 = {{13{div_q[63]}}, div_q[63:45]};
        p1_p8   = c_p8 * $signed(div_q);
        p3_m    = $signed(r_p2_xx) * c_p9;
        if (!r_p4_side.pok || r_p4_s[63]) begin
            o_press = '0;
        end else if (|r_p4_s[62:32]) begin
            o_press = 32'hFFFF_FFFF;
        end else begin
            o_press = r_p4_s[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 4; k++) begin
                r_pv[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_pv[1] <= div_vld;
            for (int k = 2; k <= 4; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
            r_ovld <= r_pv[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_ll   <= p1_xl * p1_xl;
            r_p1_lh   <= p1_xl * p1_xh32;
            r_p1_p8   <= p1_p8[63:0];
            r_p1_q    <= $signed(div_q);
            r_p1_side <= div_side;

            r_p2_xx   <= r_p1_ll + {r_p1_lh[30:0], 33'd0};
            r_p2_v2   <= r_p1_p8 >>> 19;
            r_p2_q    <= r_p1_q;
            r_p2_side <= r_p1_side;

            r_p3_m    <= p3_m[63:0];
            r_p3_v2   <= r_p2_v2;
            r_p3_q    <= r_p2_q;
            r_p3_side <= r_p2_side;

            r_p4_s    <= ((r_p3_q + (r_p3_m >>> 25) + r_p3_v2) >>> 8) + (64'(c_p7) <<< 4);
            r_p4_side <= r_p3_side;

            r_otemp  <= r_p4_side.temp;
            r_opress <= o_press;
            r_opv    <= r_p4_side.pok;
            r_ohum   <= r_p4_side.hum;
        end
    end

    assign adv      = !r_ovld || m_tready;
    assign s_tready = adv;
    assign m_tvalid = r_ovld;
    assign m_tdata  = {7'd0, r_ohum, r_opress, r_otemp};
    assign m_tuser  = r_opv;

    a_press_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[47:16] == 32'd0))
        else $error("pressure not cleared on zero divisor");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[64:48] <= CSC_HUM_OUT_MAX))
        else $error("humidity above full scale");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_fv[1])
        else $error("accepted request lost at pipeline entry");

endmodule

[test/tb.sv]
// ============================================================================
// tb: regression bench for the climate sensor compensation core
// Streams raw readings through the core under several calibration sets. A
// directed table comes first, then random readings. Each result is checked
// field by field against a local model of the integer compensation or, for
// the reset table, a fixed value. Both stream sides idle at random.
// ============================================================================
module tb;
    import csc_pkg::*;

    localparam logic [CSC_IDX_W-1:0] REG_UNUSED = 3'd6;
    localparam int IDLE_PCT   = 38;
    localparam int DRAIN_WAIT = 100;
    localparam int STALL_MAX  = 4000;

    typedef struct {
        logic [15:0] temp;
        logic [31:0] press;
        logic        pok;
        logic [16:0] hum;
    } t_reading_out;

    typedef struct {
        logic [19:0]  adc_t;
        logic [19:0]  adc_p;
        logic [15:0]  adc_h;
        bit           fixed;
        t_reading_out want;
    } t_reading_in;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [CSC_IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [CSC_OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic i_cfg_we = 1'b0;
    logic [CSC_IDX_W-1:0] i_cfg_idx = '0;
    logic [CSC_CFG_W-1:0] i_cfg_data = '0;

    logic [47:0]  calib [6];
    t_reading_in  reading_q [$];
    t_reading_out result_q [$];
    t_reading_in  cur;
    bit           calm = 1'b0;
    bit           taken = 1'b0;
    int           errors = 0;
    int           stall_cnt = 0;

    climate_sensor_compensation_core uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_reading_out compensate(logic [19:0] at, logic [19:0] ap,
                                                logic [15:0] ah);
        logic signed [63:0] ta, pa, ha;
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] h1, h2, h3, h4, h5, h6;
        logic signed [63:0] a, b, tf, v1, v2, p, x, x2, s, num;
        t_reading_out r;
        ta = at; pa = ap; ha = ah;
        t1 = calib[CSC_REG_TEMP][15:0];
        t2 = $signed(calib[CSC_REG_TEMP][31:16]);
        t3 = $signed(calib[CSC_REG_TEMP][47:32]);
        p1 = calib[CSC_REG_PRESS_A][15:0];
        p2 = $signed(calib[CSC_REG_PRESS_A][31:16]);
        p3 = $signed(calib[CSC_REG_PRESS_A][47:32]);
        p4 = $signed(calib[CSC_REG_PRESS_B][15:0]);
        p5 = $signed(calib[CSC_REG_PRESS_B][31:16]);
        p6 = $signed(calib[CSC_REG_PRESS_B][47:32]);
        p7 = $signed(calib[CSC_REG_PRESS_C][15:0]);
        p8 = $signed(calib[CSC_REG_PRESS_C][31:16]);
        p9 = $signed(calib[CSC_REG_PRESS_C][47:32]);
        h1 = calib[CSC_REG_HUMID_A][7:0];
        h2 = $signed(calib[CSC_REG_HUMID_A][23:8]);
        h3 = calib[CSC_REG_HUMID_A][31:24];
        h4 = $signed(calib[CSC_REG_HUMID_B][11:0]);
        h5 = $signed(calib[CSC_REG_HUMID_B][23:12]);
        h6 = $signed(calib[CSC_REG_HUMID_B][31:24]);

        a  = (ta >>> 3) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        b  = (ta >>> 4) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        s  = (tf * 5 + 128) >>> 8;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        r.temp = s[15:0];

        v1 = tf - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = ((64'sh0000800000000000 + v1) * p1) >>> 33;
        if (v1 == 0) begin
            r.pok = 1'b0;
            r.press = '0;
        end else begin
            r.pok = 1'b1;
            p = 1048576 - pa;
            num = ((p <<< 31) - v2) * 3125;
            if (v1 == -1) p = -num;
            else p = num / v1;
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            if (p < 0) r.press = '0;
            else if (p > 64'sd4294967295) r.press = '1;
            else r.press = p[31:0];
        end

        v1 = tf - 76800;
        a  = ((ha <<< 14) - (h4 <<< 20) - h5 * v1 + 16384) >>> 15;
        b  = ((v1 * h6) >>> 10) * (((v1 * h3) >>> 11) + 32768);
        b  = (b >>> 10) + 2097152;
        b  = (b * h2 + 8192) >>> 14;
        x  = a * b;
        x2 = x >>> 15;
        x  = x - ((((x2 * x2) >>> 7) * h1) >>> 4);
        if (x < 0) x = 0;
        if (x > CSC_HUM_MAX_Q22) x = CSC_HUM_MAX_Q22;
        x = x >>> 12;
        r.hum = x[16:0];
        return r;
    endfunction

    // sender side, plus the receiver's m_tready
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || taken)) begin
            taken = 1'b0;
            if (reading_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                cur = reading_q.pop_front();
                s_tdata <= {cur.adc_h, cur.adc_p, cur.adc_t};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge i_clk) begin
        t_reading_out got, want;
        if (i_rst_n) begin
            stall_cnt = stall_cnt + 1;
            if (s_tvalid && s_tready) begin
                stall_cnt = 0;
                taken = 1'b1;
                result_q.push_back(cur.fixed ? cur.want :
                                   compensate(cur.adc_t, cur.adc_p, cur.adc_h));
            end
            if (m_tvalid && m_tready) begin
                stall_cnt = 0;
                got.temp  = m_tdata[15:0];
                got.press = m_tdata[47:16];
                got.hum   = m_tdata[64:48];
                got.pok   = m_tuser[0];
                if (result_q.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (got.temp !== want.temp || got.press !== want.press ||
                        got.pok !== want.pok || got.hum !== want.hum) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch exp t=%h p=%h v=%b h=%h got t=%h p=%h v=%b h=%h",
                                     want.temp, want.press, want.pok, want.hum,
                                     got.temp, got.press, got.pok, got.hum);
                    end
                end
            end
            if (stall_cnt >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_calib(logic [CSC_IDX_W-1:0] idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CSC_REG_HUMID_A || idx == CSC_REG_HUMID_B) calib[idx] = {16'd0, val[31:0]};
        else if (idx <= CSC_REG_HUMID_B) calib[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_set(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb,
                            logic [47:0] pc, logic [31:0] ha, logic [31:0] hb);
        write_calib(CSC_REG_TEMP, tc);
        write_calib(CSC_REG_PRESS_A, pa);
        write_calib(CSC_REG_PRESS_B, pb);
        write_calib(CSC_REG_PRESS_C, pc);
        write_calib(CSC_REG_HUMID_A, {16'd0, ha});
        write_calib(CSC_REG_HUMID_B, {16'd0, hb});
    endtask

    task automatic queue_reading(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
        t_reading_in r;
        r.adc_t = at; r.adc_p = ap; r.adc_h = ah; r.fixed = 1'b0;
        reading_q.push_back(r);
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (reading_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] TYP_PA = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] TYP_PB = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] TYP_PC = {16'd6000, 16'hC6F8, 16'd15500};
    localparam logic [31:0] TYP_HA = {8'd0, 16'd362, 8'd75};
    localparam logic [31:0] TYP_HB = {8'd30, 12'd50, 12'd313};

    t_reading_in table_zero [4];
    logic [19:0] dir_t [10] = '{20'd0, 20'hFFFFF, 20'd519888, 20'd415148, 20'd0,
                                20'hFFFFF, 20'd600000, 20'd300000, 20'd440000, 20'd524288};
    logic [19:0] dir_p [10] = '{20'd0, 20'hFFFFF, 20'd415148, 20'd0, 20'hFFFFF,
                                20'd0, 20'd350000, 20'd500000, 20'd1048000, 20'd1};
    logic [15:0] dir_h [10] = '{16'd0, 16'hFFFF, 16'd27000, 16'hFFFF, 16'd0,
                                16'd40000, 16'd1, 16'd32768, 16'd50000, 16'd12345};

    initial begin
        int ph, k, n;
        logic [47:0] rt, rpa, rpb, rpc;
        logic [31:0] rha, rhb;
        for (k = 0; k < 6; k++) calib[k] = '0;
        // reset calibration: all coefficients zero, divisor zero
        for (k = 0; k < 4; k++) begin
            table_zero[k].adc_t = k[0] ? 20'hFFFFF : 20'd0;
            table_zero[k].adc_p = k[1] ? 20'hFFFFF : 20'd0;
            table_zero[k].adc_h = k[0] ? 16'h0000 : 16'hFFFF;
            table_zero[k].fixed = 1'b1;
            table_zero[k].want  = '{16'd0, 32'd0, 1'b0, 17'd0};
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (table_zero[k]) reading_q.push_back(table_zero[k]);
        drain();

        write_calib(REG_UNUSED, '1);
        load_set(TYP_T, TYP_PA, TYP_PB, TYP_PC, TYP_HA, TYP_HB);
        foreach (dir_t[k]) queue_reading(dir_t[k], dir_p[k], dir_h[k]);
        drain();
        load_set('1, '1, '1, '1, '1, '1);
        for (k = 0; k < 5; k++) queue_reading(dir_t[k], dir_p[k], dir_h[k]);
        drain();
        // nonzero coefficients but zero pressure divisor
        load_set(TYP_T, {TYP_PA[47:16], 16'd0}, TYP_PB, TYP_PC, TYP_HA, TYP_HB);
        for (k = 5; k < 10; k++) queue_reading(dir_t[k], dir_p[k], dir_h[k]);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            rt  = 48'({$urandom, $urandom});
            rpa = 48'({$urandom, $urandom});
            rpb = 48'({$urandom, $urandom});
            rpc = 48'({$urandom, $urandom});
            rha = $urandom;
            rhb = $urandom;
            if (ph % 3 == 0) begin
                rt  = TYP_T  ^ (rt  & 48'h00FF_00FF_00FF);
                rpa = TYP_PA ^ (rpa & 48'h00FF_00FF_00FF);
                rpb = TYP_PB ^ (rpb & 48'h000F_000F_000F);
                rpc = TYP_PC ^ (rpc & 48'h00FF_00FF_00FF);
                rha = TYP_HA ^ (rha & 32'h0F00_FF0F);
                rhb = TYP_HB ^ (rhb & 32'h0F00_F00F);
            end
            load_set(rt, rpa, rpb, rpc, rha, rhb);
            calm = (ph == 2);
            n = 92;
            for (k = 0; k < n; k++) begin
                if ($urandom_range(9) == 0)
                    queue_reading($urandom_range(1) ? 20'hFFFFF : 20'd0,
                                  $urandom_range(1) ? 20'hFFFFF : 20'd0,
                                  $urandom_range(1) ? 16'hFFFF : 16'd0);
                else if (ph % 3 == 0)
                    queue_reading(20'($urandom_range(600000, 400000)),
                                  20'($urandom_range(500000, 250000)), 16'($urandom));
                else
                    queue_reading(20'($urandom), 20'($urandom), 16'($urandom));
            end
            drain();
            calm = 1'b0;
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
